[hdl/dqd_pkg.sv]
// Shared types and constants for the dual quadrature decoder.
// No dependencies; dqd_channel, the top level and the checker import this package.
`default_nettype none

package dqd_pkg;

	// Counter width default and width of the count/preset fields on the ports
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int FIELD_W         = 16;

	// Counter value after reset, masked to the counter width where used
	localparam logic [31:0] RESET_COUNT = 32'd32767;

	typedef logic [1:0] phase_t;

	// Per-channel event codes
	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_INC  = 2'd1,
		EV_DEC  = 2'd2,
		EV_BAD  = 2'd3
	} evt_t;

	// Request kinds
	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_PRESET = 1'b1
	} req_kind_t;

	// Gray-code neighbors of each phase: slot 0 first, slot 1 second
	localparam phase_t SUCC_TBL [4][2] = '{
		'{2'd1, 2'd2},
		'{2'd3, 2'd0},
		'{2'd0, 2'd3},
		'{2'd2, 2'd1}
	};

	// Control from the top level to each channel
	typedef struct packed {
		logic advance;
		logic preset;
	} chan_ctrl_t;

endpackage

`default_nettype wire

[hdl/dqd_req_if.sv]
// Request channel: valid/ready handshake carrying one sample or preset beat.
// Standalone interface, no package dependency.
`default_nettype none

interface dqd_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [1:0]  left_phase;
	logic [1:0]  right_phase;
	logic [15:0] preset_value;

	modport source (
		output valid, req_type, left_phase, right_phase, preset_value,
		input  ready
	);
	modport sink (
		input  valid, req_type, left_phase, right_phase, preset_value,
		output ready
	);
endinterface

`default_nettype wire

[hdl/dqd_rsp_if.sv]
// Response channel: valid/ready handshake carrying both counts and events.
// Standalone interface, no package dependency.
`default_nettype none

interface dqd_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] left_count;
	logic [15:0] right_count;
	logic [1:0]  left_event;
	logic [1:0]  right_event;

	modport source (
		output valid, left_count, right_count, left_event, right_event,
		input  ready
	);
	modport sink (
		input  valid, left_count, right_count, left_event, right_event,
		output ready
	);
endinterface

`default_nettype wire

[hdl/dqd_channel.sv]
// One decoder channel: position counter, last phase and the x4 step decode.
// Depends on dqd_pkg.
`default_nettype none

module dqd_channel #(
	parameter int   COUNT_WIDTH = dqd_pkg::COUNT_WIDTH_DEF,
	parameter logic UP_SLOT     = 1'b1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dqd_pkg::chan_ctrl_t    ctrl,
	input  dqd_pkg::phase_t        phase,
	input  logic [COUNT_WIDTH-1:0] preset_value,
	output logic [COUNT_WIDTH-1:0] count_nxt,
	output dqd_pkg::evt_t          evt_nxt
);
	import dqd_pkg::*;

	logic [COUNT_WIDTH-1:0] count_q;
	phase_t                 last_q;

	// Step decode against the neighbors of the last phase
	always_comb begin
		count_nxt = count_q;
		evt_nxt   = EV_NONE;
		if (ctrl.preset) begin
			count_nxt = preset_value;
		end else if (phase == last_q) begin
			evt_nxt = EV_NONE;
		end else if (phase == SUCC_TBL[last_q][UP_SLOT]) begin
			count_nxt = count_q + COUNT_WIDTH'(1);
			evt_nxt   = EV_INC;
		end else if (phase == SUCC_TBL[last_q][~UP_SLOT]) begin
			count_nxt = count_q - COUNT_WIDTH'(1);
			evt_nxt   = EV_DEC;
		end else begin
			evt_nxt = EV_BAD;
		end
	end

	// Channel state; a preset leaves the last phase alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RESET_COUNT[COUNT_WIDTH-1:0];
			last_q  <= '0;
		end else if (ctrl.advance) begin
			count_q <= count_nxt;
			if (!ctrl.preset) begin
				last_q <= phase;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/dual_quadrature_decoder_top.sv]
// Top level of the two-channel x4 quadrature decoder.
// Depends on dqd_pkg, dqd_req_if, dqd_rsp_if and dqd_channel.
//
// Each request beat is either a phase sample for both encoders or a preset
// that loads both position counters; every beat returns exactly one response
// with both counts and a per-channel event code (none, up, down, or an
// invalid two-step jump that leaves the count alone). Beats go through an
// input register and then a result register, from which the response is
// offered. One beat is taken every cycle as long as the response side keeps
// taking results. The count and last-phase registers of each channel are
// read, updated and written back in that single cycle.
// Counters are COUNT_WIDTH bits, reset to 32767 masked to that width, and
// wrap; counts are shown on 16-bit fields (zero-extended or truncated).
`default_nettype none

module dual_quadrature_decoder_top #(
	parameter int COUNT_WIDTH = dqd_pkg::COUNT_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	dqd_req_if.sink   req,
	dqd_rsp_if.source rsp
);
	import dqd_pkg::*;

	// Input register
	logic                  valid_s1;
	req_kind_t             req_type_s1;
	phase_t                left_phase_s1;
	phase_t                right_phase_s1;
	logic [FIELD_W-1:0]    preset_value_s1;

	// Result register
	logic                  valid_s2;
	logic [FIELD_W-1:0]    left_count_s2;
	logic [FIELD_W-1:0]    right_count_s2;
	evt_t                  left_event_s2;
	evt_t                  right_event_s2;

	logic                        adv_s1;
	chan_ctrl_t                  ctrl;
	logic [COUNT_WIDTH+FIELD_W-1:0] preset_ext;
	logic [COUNT_WIDTH-1:0]      preset_cw;
	logic [COUNT_WIDTH-1:0]      left_cnt_nxt;
	logic [COUNT_WIDTH-1:0]      right_cnt_nxt;
	logic [COUNT_WIDTH+FIELD_W-1:0] left_cnt_ext;
	logic [COUNT_WIDTH+FIELD_W-1:0] right_cnt_ext;
	evt_t                        left_evt_nxt;
	evt_t                        right_evt_nxt;

	// Handshake: stage 1 moves when the result register is free or draining
	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;

	assign ctrl.advance = adv_s1;
	assign ctrl.preset  = (req_type_s1 == REQ_PRESET);

	// Width adaptation between 16-bit fields and the counters
	assign preset_ext    = {{COUNT_WIDTH{1'b0}}, preset_value_s1};
	assign preset_cw     = preset_ext[COUNT_WIDTH-1:0];
	assign left_cnt_ext  = {{FIELD_W{1'b0}}, left_cnt_nxt};
	assign right_cnt_ext = {{FIELD_W{1'b0}}, right_cnt_nxt};

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1     <= req_kind_t'(req.req_type);
			left_phase_s1   <= req.left_phase;
			right_phase_s1  <= req.right_phase;
			preset_value_s1 <= req.preset_value;
		end
	end

	// Left channel counts up on the second neighbor
	dqd_channel #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.UP_SLOT     (1'b1)
	) u_left (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.phase        (left_phase_s1),
		.preset_value (preset_cw),
		.count_nxt    (left_cnt_nxt),
		.evt_nxt      (left_evt_nxt)
	);

	// Right channel counts up on the first neighbor
	dqd_channel #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.UP_SLOT     (1'b0)
	) u_right (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.phase        (right_phase_s1),
		.preset_value (preset_cw),
		.count_nxt    (right_cnt_nxt),
		.evt_nxt      (right_evt_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			left_count_s2  <= left_cnt_ext[FIELD_W-1:0];
			right_count_s2 <= right_cnt_ext[FIELD_W-1:0];
			left_event_s2  <= left_evt_nxt;
			right_event_s2 <= right_evt_nxt;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.left_count  = left_count_s2;
	assign rsp.right_count = right_count_s2;
	assign rsp.left_event  = left_event_s2;
	assign rsp.right_event = right_event_s2;

endmodule

`default_nettype wire

[hdl/dqd_checker.sv]
// Port-level checks for the dual quadrature decoder, bound to the top level.
// Depends on dqd_pkg and dual_quadrature_decoder_top.
`default_nettype none

module dqd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] left_count,
	input logic [15:0] right_count,
	input logic [1:0]  left_event,
	input logic [1:0]  right_event
);
	import dqd_pkg::*;

	logic        in_acc;
	logic        out_acc;
	logic [2:0]  pend_q;
	logic        seen_q;
	logic [15:0] lcnt_q;
	logic [15:0] rcnt_q;

	assign in_acc  = req_valid && req_ready;
	assign out_acc = rsp_valid && rsp_ready;

	// Beats in flight and the counts of the last delivered response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			seen_q <= 1'b0;
			lcnt_q <= '0;
			rcnt_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b0, in_acc} - {2'b0, out_acc};
			if (out_acc) begin
				seen_q <= 1'b1;
				lcnt_q <= left_count;
				rcnt_q <= right_count;
			end
		end
	end

	// A stalled response stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// A stalled response keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(left_count) && $stable(right_count)
			&& $stable(left_event) && $stable(right_event))
		else $error("response payload changed while stalled");

	// Every response answers a request still in flight
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 3'd0)
		else $error("response without a pending request");

	// Two register stages hold at most two beats
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("more beats in flight than stages");

	// An invalid jump leaves that channel's count where the last response left it
	a_bad_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen_q && (left_event == EV_BAD || right_event == EV_BAD)
		|-> (left_event != EV_BAD || left_count == lcnt_q)
			&& (right_event != EV_BAD || right_count == rcnt_q))
		else $error("count moved on an invalid jump");

endmodule

bind dual_quadrature_decoder_top dqd_checker u_dqd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.left_count  (rsp.left_count),
	.right_count (rsp.right_count),
	.left_event  (rsp.left_event),
	.right_event (rsp.right_event)
);

`default_nettype wire
